[rtl/tccs_pkg.sv]
// Shared constants, codes and controller/datapath link types for the console engine.
package tccs_pkg;

  localparam int unsigned SCREEN_COLUMNS = 80;
  localparam int unsigned SCREEN_ROWS    = 25;
  localparam int unsigned REGION_CELLS   = 4096;
  localparam int unsigned CONSOLE_COUNT  = 4;

  localparam int unsigned SCREEN_CELLS = SCREEN_COLUMNS * SCREEN_ROWS;

  // console_index is two bits wide, so four slots cover every code
  localparam int unsigned CONS_W     = 2;
  localparam int unsigned CONS_SLOTS = 2 ** CONS_W;

  // internal address width: room for the top region end plus one line
  localparam int unsigned AW     = $clog2(CONS_SLOTS * REGION_CELLS) + 1;
  localparam int unsigned OUT_AW = 14;
  localparam int unsigned COL_W  = $clog2(SCREEN_COLUMNS);

  localparam logic [1:0] OP_WRITE       = 2'd0;
  localparam logic [1:0] OP_SCROLL_UP   = 2'd1;
  localparam logic [1:0] OP_SCROLL_DOWN = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_BLANK     = 8'd32;

  localparam logic [7:0] ATTR_RESET = 8'd7;

  typedef struct packed {
    logic load;
    logic exec;
    logic scroll;
    logic commit;
  } tccs_cmd_t;

  typedef struct packed {
    logic scroll_more;
    logic out_free;
  } tccs_sts_t;

endpackage

[rtl/tccs_ifs.sv]
// Channel interfaces: input item, result item and attribute register write.
interface tccs_item_if import tccs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [1:0] console_index;
  logic [7:0] character;
  logic       end_of_write;

  modport source (output valid, operation, console_index, character, end_of_write,
                  input ready);
  modport sink   (input valid, operation, console_index, character, end_of_write,
                  output ready);
endinterface

interface tccs_result_if import tccs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cell_write;
  logic [OUT_AW-1:0] cell_address;
  logic [7:0]        cell_char;
  logic [7:0]        cell_attr;
  logic [OUT_AW-1:0] cursor_position;
  logic [OUT_AW-1:0] display_start;
  logic              write_done;

  modport source (output valid, cell_write, cell_address, cell_char, cell_attr,
                  cursor_position, display_start, write_done, input ready);
  modport sink   (input valid, cell_write, cell_address, cell_char, cell_attr,
                  cursor_position, display_start, write_done, output ready);
endinterface

interface tccs_cfg_if ();
  logic       valid;
  logic       ready;
  logic [7:0] text_attribute;

  modport source (output valid, text_attribute, input ready);
  modport sink   (input valid, text_attribute, output ready);
endinterface

[rtl/tccs_dpath.sv]
// Datapath: per-console cursor/column/start registers, working item and result register.
module tccs_dpath import tccs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tccs_cmd_t         cmd_i,
  output tccs_sts_t         sts_o,
  input  logic [1:0]        op_i,
  input  logic [CONS_W-1:0] cons_i,
  input  logic [7:0]        char_i,
  input  logic              eow_i,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_attr_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              cell_write_o,
  output logic [OUT_AW-1:0] cell_address_o,
  output logic [7:0]        cell_char_o,
  output logic [7:0]        cell_attr_o,
  output logic [OUT_AW-1:0] cursor_position_o,
  output logic [OUT_AW-1:0] display_start_o,
  output logic              write_done_o
);

  logic [AW-1:0]    cur_arr_q [CONS_SLOTS];
  logic [AW-1:0]    st_arr_q  [CONS_SLOTS];
  logic [COL_W-1:0] col_arr_q [CONS_SLOTS];
  logic [7:0]       attr_q;

  logic [1:0]        op_q;
  logic [CONS_W-1:0] cons_q;
  logic [7:0]        char_q;
  logic              eow_q;
  logic [AW-1:0]     cur_q, cur_d;
  logic [AW-1:0]     st_q, st_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              wr_q, wr_d;
  logic [AW-1:0]     waddr_q, waddr_d;
  logic [7:0]        wchar_q, wchar_d;

  logic              out_valid_q;
  logic              out_wr_q;
  logic [OUT_AW-1:0] out_addr_q;
  logic [7:0]        out_char_q;
  logic [7:0]        out_attr_q;
  logic [OUT_AW-1:0] out_cur_q;
  logic [OUT_AW-1:0] out_st_q;
  logic              out_done_q;

  logic [AW-1:0] base_w, end_w, st_bottom_w;
  logic          cons_ok_w, down_fits_w;

  assign base_w      = AW'(cons_q) * AW'(REGION_CELLS);
  assign end_w       = base_w + AW'(REGION_CELLS);
  assign st_bottom_w = st_q + AW'(SCREEN_CELLS);
  assign down_fits_w = st_bottom_w < end_w;
  assign cons_ok_w   = 32'(cons_q) < 32'(CONSOLE_COUNT);

  assign sts_o.scroll_more = cons_ok_w && (op_q == OP_WRITE) && (cur_q >= st_bottom_w)
                             && down_fits_w;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  // one item step: character handling or a single-line scroll
  always_comb begin
    cur_d   = cur_q;
    st_d    = st_q;
    col_d   = col_q;
    wr_d    = 1'b0;
    waddr_d = '0;
    wchar_d = '0;
    if (cons_ok_w) begin
      case (op_q)
        OP_WRITE: begin
          if (char_q == CHAR_NEWLINE) begin
            if (cur_q + AW'(SCREEN_COLUMNS) < end_w) begin
              cur_d = cur_q - AW'(col_q) + AW'(SCREEN_COLUMNS);
              col_d = '0;
            end
          end else if (char_q == CHAR_BACKSPACE) begin
            if (cur_q > base_w) begin
              cur_d   = cur_q - AW'(1);
              col_d   = (col_q == '0) ? COL_W'(SCREEN_COLUMNS - 1) : col_q - COL_W'(1);
              wr_d    = 1'b1;
              waddr_d = cur_q - AW'(1);
              wchar_d = CHAR_BLANK;
            end
          end else begin
            if (cur_q + AW'(1) < end_w) begin
              cur_d   = cur_q + AW'(1);
              col_d   = (col_q == COL_W'(SCREEN_COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
              wr_d    = 1'b1;
              waddr_d = cur_q;
              wchar_d = char_q;
            end
          end
        end
        OP_SCROLL_UP: begin
          if (st_q > base_w) begin
            st_d = (st_q - base_w >= AW'(SCREEN_COLUMNS)) ? st_q - AW'(SCREEN_COLUMNS)
                                                         : base_w;
          end
        end
        OP_SCROLL_DOWN: begin
          if (down_fits_w) begin
            st_d = st_q + AW'(SCREEN_COLUMNS);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CONS_SLOTS; c++) begin
        cur_arr_q[c] <= AW'(c * REGION_CELLS);
        st_arr_q[c]  <= AW'(c * REGION_CELLS);
        col_arr_q[c] <= '0;
      end
      attr_q      <= ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        attr_q <= cfg_attr_i;
      end
      if (cmd_i.commit) begin
        if (cons_ok_w) begin
          cur_arr_q[cons_q] <= cur_q;
          st_arr_q[cons_q]  <= st_q;
          col_arr_q[cons_q] <= col_q;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      cons_q <= cons_i;
      char_q <= char_i;
      eow_q  <= eow_i;
      cur_q  <= cur_arr_q[cons_i];
      st_q   <= st_arr_q[cons_i];
      col_q  <= col_arr_q[cons_i];
    end
    if (cmd_i.exec) begin
      cur_q   <= cur_d;
      st_q    <= st_d;
      col_q   <= col_d;
      wr_q    <= wr_d;
      waddr_q <= waddr_d;
      wchar_q <= wchar_d;
    end
    if (cmd_i.scroll) begin
      st_q <= st_q + AW'(SCREEN_COLUMNS);
    end
    if (cmd_i.commit) begin
      out_wr_q   <= wr_q;
      out_addr_q <= waddr_q[OUT_AW-1:0];
      out_char_q <= wchar_q;
      out_attr_q <= wr_q ? attr_q : 8'd0;
      out_cur_q  <= cons_ok_w ? cur_q[OUT_AW-1:0] : '0;
      out_st_q   <= cons_ok_w ? st_q[OUT_AW-1:0] : '0;
      out_done_q <= eow_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cell_write_o      = out_wr_q;
  assign cell_address_o    = out_addr_q;
  assign cell_char_o       = out_char_q;
  assign cell_attr_o       = out_attr_q;
  assign cursor_position_o = out_cur_q;
  assign display_start_o   = out_st_q;
  assign write_done_o      = out_done_q;

endmodule

[rtl/tccs_ctrl.sv]
// Controller: sequences load, execute, scroll iterations and commit of one word.
module tccs_ctrl import tccs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tccs_sts_t sts_i,
  output tccs_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:   cmd_o.load = in_valid_i;
      ST_EXEC:   cmd_o.exec = 1'b1;
      ST_FINISH: begin
        cmd_o.scroll = sts_i.scroll_more;
        cmd_o.commit = !sts_i.scroll_more && sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE:   if (in_valid_i) state_q <= ST_EXEC;
        ST_EXEC:   state_q <= ST_FINISH;
        ST_FINISH: if (!sts_i.scroll_more && sts_i.out_free) state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/text_console_cursor_scroll.sv]
// Top level: text console cursor and scroll engine.
//
//   channel   dir  handshake        word
//   item_i    in   valid/ready      operation, console_index, character, end_of_write
//   result_o  out  valid/ready      cell write, cursor position, display start, done
//   cfg_i     in   valid/ready      text_attribute (always ready)
//
// A word passes through accept, execute and commit, plus a scroll step for each line the
// display start moves down after a character; that loop sets the rate.
// Reset puts every cursor and start at its region base and the attribute at 7.
// A new word is accepted while the previous result waits in the output register;
// commit waits out the scroll steps and stalls while that register is full and not taken.
module text_console_cursor_scroll import tccs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  tccs_item_if.sink     item_i,
  tccs_result_if.source result_o,
  tccs_cfg_if.sink      cfg_i
);

  tccs_cmd_t cmd;
  tccs_sts_t sts;
  logic      in_ready;

  assign item_i.ready = in_ready;
  assign cfg_i.ready  = 1'b1;

  tccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tccs_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .op_i              (item_i.operation),
    .cons_i            (item_i.console_index),
    .char_i            (item_i.character),
    .eow_i             (item_i.end_of_write),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_attr_i        (cfg_i.text_attribute),
    .out_valid_o       (result_o.valid),
    .out_ready_i       (result_o.ready),
    .cell_write_o      (result_o.cell_write),
    .cell_address_o    (result_o.cell_address),
    .cell_char_o       (result_o.cell_char),
    .cell_attr_o       (result_o.cell_attr),
    .cursor_position_o (result_o.cursor_position),
    .display_start_o   (result_o.display_start),
    .write_done_o      (result_o.write_done)
  );

endmodule
